// ----- rtl/mta_pkg.sv -----
// ----------------------------------------------------------------------------
// mta_pkg
// Shared constants, storage word types, unit handshake structs and helpers
// for the mesh tangent accumulator.
// ----------------------------------------------------------------------------
package mta_pkg;

   localparam int VERTEX_COUNT = 4096;
   localparam int ADDR_W       = $clog2(VERTEX_COUNT);
   localparam int IDX_W        = 12;
   localparam int DATA_W       = 32;
   localparam int QUOT_W       = 32;

   typedef enum logic [1:0] {
      KIND_LOAD_GEO = 2'd0,
      KIND_LOAD_TAN = 2'd1,
      KIND_TRIANGLE = 2'd2,
      KIND_READ_TAN = 2'd3
   } kind_type;

   // position and texcoord of one vertex, all Q16.16
   typedef struct packed {
      logic [DATA_W-1:0] px;
      logic [DATA_W-1:0] py;
      logic [DATA_W-1:0] pz;
      logic [DATA_W-1:0] tu;
      logic [DATA_W-1:0] tv;
   } geo_word_type;

   // tangent of one vertex, Q2.30, element 0 is x
   typedef logic [2:0][DATA_W-1:0] tan_word_type;

   typedef struct packed {
      logic              start;
      logic [63:0]       hi;
      logic [QUOT_W-1:0] lo;
      logic [63:0]       den;
   } div_req_type;

   typedef struct packed {
      logic        start;
      logic [63:0] radicand;
   } sqrt_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

   // a - b, saturated to the signed 31-bit range
   function automatic logic signed [30:0] diff31(input logic [31:0] a,
                                                 input logic [31:0] b);
      logic signed [32:0] d;
      d = $signed({a[31], a}) - $signed({b[31], b});
      if (d > $signed(33'h0_3FFF_FFFF)) begin
         return 31'h3FFF_FFFF;
      end else if (d < $signed(33'h1_C000_0000)) begin
         return 31'h4000_0000;
      end else begin
         return d[30:0];
      end
   endfunction

endpackage

// ----- rtl/mta_vstore.sv -----
// ----------------------------------------------------------------------------
// mta_vstore
// Vertex store: a geometry memory (position and texcoord) and a tangent
// memory, each with one write port and one registered read port.
// ----------------------------------------------------------------------------
module mta_vstore (
   input  logic                         clock,
   input  logic                         geo_we,
   input  logic [mta_pkg::ADDR_W-1:0]   geo_waddr,
   input  mta_pkg::geo_word_type        geo_wdata,
   input  logic [mta_pkg::ADDR_W-1:0]   geo_raddr,
   output mta_pkg::geo_word_type        geo_rdata,
   input  logic                         tan_we,
   input  logic [mta_pkg::ADDR_W-1:0]   tan_waddr,
   input  mta_pkg::tan_word_type        tan_wdata,
   input  logic [mta_pkg::ADDR_W-1:0]   tan_raddr,
   output mta_pkg::tan_word_type        tan_rdata
);

   mta_pkg::geo_word_type geo_mem [mta_pkg::VERTEX_COUNT];
   mta_pkg::tan_word_type tan_mem [mta_pkg::VERTEX_COUNT];

   always_ff @(posedge clock) begin
      if (geo_we) begin
         geo_mem[geo_waddr] <= geo_wdata;
      end
      geo_rdata <= geo_mem[geo_raddr];
   end

   always_ff @(posedge clock) begin
      if (tan_we) begin
         tan_mem[tan_waddr] <= tan_wdata;
      end
      tan_rdata <= tan_mem[tan_raddr];
   end

endmodule

// ----- rtl/mta_divider.sv -----
// ----------------------------------------------------------------------------
// mta_divider
// Restoring divider, one quotient bit per cycle. Divides {hi, lo} by den
// with hi < den, giving a QUOT_W-bit quotient.
// ----------------------------------------------------------------------------
module mta_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  mta_pkg::div_req_type        req,
   output mta_pkg::unit_status_type    status,
   output logic [mta_pkg::QUOT_W-1:0]  quot
);

   localparam int CNT_W = $clog2(mta_pkg::QUOT_W + 1);

   logic [63:0]               rem_ff,  rem_in;
   logic [mta_pkg::QUOT_W-1:0] lo_ff,   lo_in;
   logic [63:0]               den_ff,  den_in;
   logic [mta_pkg::QUOT_W-1:0] quot_ff, quot_in;
   logic [CNT_W-1:0]          cnt_ff,  cnt_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [63:0]               shifted;
   logic                      fits;

   assign shifted = {rem_ff[62:0], lo_ff[mta_pkg::QUOT_W-1]};
   assign fits    = shifted >= den_ff;

   always_comb begin
      rem_in  = rem_ff;
      lo_in   = lo_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = req.hi;
         lo_in   = req.lo;
         den_in  = req.den;
         cnt_in  = CNT_W'(mta_pkg::QUOT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         rem_in  = fits ? (shifted - den_ff) : shifted;
         lo_in   = {lo_ff[mta_pkg::QUOT_W-2:0], 1'b0};
         quot_in = {quot_ff[mta_pkg::QUOT_W-2:0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      lo_ff   <= lo_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quot        = quot_ff;

endmodule

// ----- rtl/mta_sqrt.sv -----
// ----------------------------------------------------------------------------
// mta_sqrt
// Floor integer square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module mta_sqrt (
   input  logic                      clock,
   input  logic                      reset,
   input  mta_pkg::sqrt_req_type     req,
   output mta_pkg::unit_status_type  status,
   output logic [31:0]               root
);

   logic [63:0] x_ff,   x_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] bit_ff, bit_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [63:0] trial;

   assign trial = res_ff + bit_ff;

   always_comb begin
      x_in    = x_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         x_in    = req.radicand;
         res_in  = '0;
         bit_in  = 64'h4000_0000_0000_0000;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (x_ff >= trial) begin
            x_in   = x_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign root        = res_ff[31:0];

endmodule

// ----- rtl/mesh_tangent_accumulator.sv -----
// ----------------------------------------------------------------------------
// mesh_tangent_accumulator
// Vertex store with per-triangle face tangent generation and accumulation
// of normalized corner tangents.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake            Payload
// req      in   req_valid/req_ready  kind, three indices, value xyz, tex uv, last
// rsp      out  rsp_valid/rsp_ready  index, tangent xyz, degenerate, mesh_done
//
// One item is in work at a time. A triangle runs three face divisions
// (skipped when the determinant is zero or the component saturates) and,
// per corner, a normalizing shift, a square root on its own serial unit
// and three divisions on the shared serial divider; a zero-length corner
// sum skips the root and the divisions and writes a zero tangent back.
// Reset clears only control state; the vertex memories hold garbage until
// written. A waiting result sits in the output register and does not block
// the next transfer on req; a finished item waits only if that register
// is still full.
// ----------------------------------------------------------------------------
module mesh_tangent_accumulator (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_kind,
   input  logic [11:0]         req_vertex_index,
   input  logic [11:0]         req_second_index,
   input  logic [11:0]         req_third_index,
   input  logic signed [31:0]  req_value_x,
   input  logic signed [31:0]  req_value_y,
   input  logic signed [31:0]  req_value_z,
   input  logic signed [31:0]  req_tex_u,
   input  logic signed [31:0]  req_tex_v,
   input  logic                req_last_triangle,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [11:0]         rsp_out_index,
   output logic signed [31:0]  rsp_tangent_x,
   output logic signed [31:0]  rsp_tangent_y,
   output logic signed [31:0]  rsp_tangent_z,
   output logic                rsp_degenerate,
   output logic                rsp_mesh_done
);

   localparam int AW = mta_pkg::ADDR_W;

   typedef enum logic [17:0] {
      S_IDLE      = 18'h00001,
      S_DISPATCH  = 18'h00002,
      S_GEO_RD    = 18'h00004,
      S_MUL       = 18'h00008,
      S_MACC      = 18'h00010,
      S_FACE      = 18'h00020,
      S_FACE_WAIT = 18'h00040,
      S_TAN_RD    = 18'h00080,
      S_TAN_CAP   = 18'h00100,
      S_NORM      = 18'h00200,
      S_SQ        = 18'h00400,
      S_SQ_ACC    = 18'h00800,
      S_SQRT_WAIT = 18'h01000,
      S_NDIV      = 18'h02000,
      S_NDIV_WAIT = 18'h04000,
      S_TAN_WR    = 18'h08000,
      S_RD_CAP    = 18'h10000,
      S_RESP      = 18'h20000
   } state_type;

   function automatic logic signed [31:0] sx31(input logic signed [30:0] v);
      return {v[30], v};
   endfunction

   // control
   state_type   state_ff, state_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  step_ff, step_in;
   logic [1:0]  comp_ff, comp_in;
   logic [1:0]  sel_ff, sel_in;

   // item and working registers
   mta_pkg::kind_type kind_ff, kind_in;
   logic [11:0]        index_ff, index_in;
   logic [AW-1:0]      corner_ff [3];
   logic [AW-1:0]      corner_in [3];
   logic [31:0]        val_ff [3];
   logic [31:0]        val_in [3];
   logic [31:0]        tu_ff, tu_in, tv_ff, tv_in;
   logic               last_ff, last_in;
   mta_pkg::geo_word_type base_ff, base_in;
   logic signed [30:0] e1_ff [3];
   logic signed [30:0] e1_in [3];
   logic signed [30:0] e2_ff [3];
   logic signed [30:0] e2_in [3];
   logic signed [30:0] du1_ff, du1_in, du2_ff, du2_in;
   logic signed [30:0] dv1_ff, dv1_in, dv2_ff, dv2_in;
   logic signed [63:0] prod_ff, prod_in, acc_ff, acc_in, det_ff, det_in;
   logic signed [63:0] num_ff [3];
   logic signed [63:0] num_in [3];
   logic [31:0]        face_ff [3];
   logic [31:0]        face_in [3];
   logic               sign_ff [3];
   logic               sign_in [3];
   logic [32:0]        mag_ff [3];
   logic [32:0]        mag_in [3];
   logic [32:0]        mx_ff, mx_in;
   logic [63:0]        sq_ff, sq_in;
   logic [31:0]        len_ff, len_in;
   logic [31:0]        newtan_ff [3];
   logic [31:0]        newtan_in [3];
   logic [11:0]        rsp_index_ff, rsp_index_in;
   logic [31:0]        rsp_tan_ff [3];
   logic [31:0]        rsp_tan_in [3];
   logic               rsp_degen_ff, rsp_degen_in, rsp_done_ff, rsp_done_in;

   // memory ports
   logic                  geo_we;
   logic [AW-1:0]         geo_raddr;
   mta_pkg::geo_word_type geo_wdata, geo_rdata;
   logic                  tan_we;
   logic [AW-1:0]         tan_waddr;
   mta_pkg::tan_word_type tan_wdata, tan_rdata;

   // arithmetic units
   mta_pkg::div_req_type     div_req;
   mta_pkg::unit_status_type div_status;
   logic [31:0]              div_quot;
   mta_pkg::sqrt_req_type    sqrt_req;
   mta_pkg::unit_status_type sqrt_status;
   logic [31:0]              sqrt_root;

   // datapath helpers
   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] mul_p;
   logic signed [63:0] num_cur;
   logic [63:0]        num_mag, det_mag;
   logic               face_neg, face_over;
   logic [32:0]        face_round;
   logic [31:0]        face_val;
   logic [1:0]         mag_idx;
   logic [30:0]        mag_cur;
   logic [63:0]        nx, nx2;
   logic [31:0]        ndiv_m;
   logic signed [32:0] tsum [3];
   logic               accept;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);

   mta_vstore u_vstore (
      .clock     (clock),
      .geo_we    (geo_we),
      .geo_waddr (corner_ff[0]),
      .geo_wdata (geo_wdata),
      .geo_raddr (geo_raddr),
      .geo_rdata (geo_rdata),
      .tan_we    (tan_we),
      .tan_waddr (tan_waddr),
      .tan_wdata (tan_wdata),
      .tan_raddr (corner_ff[sel_ff]),
      .tan_rdata (tan_rdata)
   );

   mta_divider u_divider (
      .clock  (clock),
      .reset  (reset),
      .req    (div_req),
      .status (div_status),
      .quot   (div_quot)
   );

   mta_sqrt u_sqrt (
      .clock  (clock),
      .reset  (reset),
      .req    (sqrt_req),
      .status (sqrt_status),
      .root   (sqrt_root)
   );

   // memory port steering
   assign geo_we    = (state_ff == S_DISPATCH) && (kind_ff == mta_pkg::KIND_LOAD_GEO);
   assign geo_wdata = '{px: val_ff[0], py: val_ff[1], pz: val_ff[2], tu: tu_ff, tv: tv_ff};
   assign geo_raddr = (step_ff[1:0] == 2'd3) ? corner_ff[0] : corner_ff[step_ff[1:0]];
   assign tan_we    = ((state_ff == S_DISPATCH) && (kind_ff == mta_pkg::KIND_LOAD_TAN))
                      || (state_ff == S_TAN_WR);
   assign tan_waddr = (state_ff == S_TAN_WR) ? corner_ff[sel_ff] : corner_ff[0];
   assign tan_wdata = (state_ff == S_TAN_WR)
                      ? {newtan_ff[2], newtan_ff[1], newtan_ff[0]}
                      : {val_ff[2], val_ff[1], val_ff[0]};

   // shared multiplier: cross products of the deltas, then squares
   assign mag_idx = (state_ff == S_SQ) ? step_ff[1:0] : comp_ff;
   assign mag_cur = mag_ff[mag_idx][30:0];

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == S_SQ) begin
         mul_a = $signed({1'b0, mag_cur});
         mul_b = $signed({1'b0, mag_cur});
      end else begin
         unique case (step_ff)
            3'd0: begin mul_a = sx31(du1_ff); mul_b = sx31(dv2_ff);   end
            3'd1: begin mul_a = sx31(du2_ff); mul_b = sx31(dv1_ff);   end
            3'd2: begin mul_a = sx31(dv2_ff); mul_b = sx31(e1_ff[0]); end
            3'd3: begin mul_a = sx31(dv1_ff); mul_b = sx31(e2_ff[0]); end
            3'd4: begin mul_a = sx31(dv2_ff); mul_b = sx31(e1_ff[1]); end
            3'd5: begin mul_a = sx31(dv1_ff); mul_b = sx31(e2_ff[1]); end
            3'd6: begin mul_a = sx31(dv2_ff); mul_b = sx31(e1_ff[2]); end
            3'd7: begin mul_a = sx31(dv1_ff); mul_b = sx31(e2_ff[2]); end
         endcase
      end
   end

   assign mul_p = mul_a * mul_b;

   // face tangent: num * 2^30 / det, rounded half away from zero
   assign num_cur    = num_ff[comp_ff];
   assign num_mag    = num_cur[63] ? 64'(-num_cur) : 64'(num_cur);
   assign det_mag    = det_ff[63] ? 64'(-det_ff) : 64'(det_ff);
   assign face_neg   = num_cur[63] ^ det_ff[63];
   assign face_over  = num_mag >= {det_mag[62:0], 1'b0};
   assign face_round = ({1'b0, div_quot} + 33'd1) >> 1;

   always_comb begin
      if (face_neg) begin
         face_val = face_over ? 32'h8000_0000 : (~face_round[31:0] + 32'd1);
      end else if (face_over || (face_round > 33'h0_7FFF_FFFF)) begin
         face_val = 32'h7FFF_FFFF;
      end else begin
         face_val = face_round[31:0];
      end
   end

   // normalize: (a * 2^30 + len/2) / len, divided at twice the scale
   assign nx     = ({33'd0, mag_cur} << 30) + {33'd0, len_ff[31:1]};
   assign nx2    = {nx[62:0], 1'b0};
   assign ndiv_m = {1'b0, div_quot[31:1]};

   always_comb begin
      div_req.start = ((state_ff == S_FACE) && (det_ff != '0) && !face_over)
                      || (state_ff == S_NDIV);
      if (state_ff == S_NDIV) begin
         div_req.hi  = {32'd0, nx2[63:32]};
         div_req.lo  = nx2[31:0];
         div_req.den = {32'd0, len_ff};
      end else begin
         div_req.hi  = {1'b0, num_mag[63:1]};
         div_req.lo  = {num_mag[0], 31'd0};
         div_req.den = det_mag;
      end
   end

   assign sqrt_req.start    = (state_ff == S_SQ_ACC) && (step_ff == 3'd2);
   assign sqrt_req.radicand = sq_ff + 64'(prod_ff);

   for (genvar k = 0; k < 3; k++) begin : g_tsum
      assign tsum[k] = $signed({tan_rdata[k][31], tan_rdata[k]})
                     + $signed({face_ff[k][31], face_ff[k]});
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      step_in      = step_ff;
      comp_in      = comp_ff;
      sel_in       = sel_ff;
      kind_in      = kind_ff;
      index_in     = index_ff;
      corner_in    = corner_ff;
      val_in       = val_ff;
      tu_in        = tu_ff;
      tv_in        = tv_ff;
      last_in      = last_ff;
      base_in      = base_ff;
      e1_in        = e1_ff;
      e2_in        = e2_ff;
      du1_in       = du1_ff;
      du2_in       = du2_ff;
      dv1_in       = dv1_ff;
      dv2_in       = dv2_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      det_in       = det_ff;
      num_in       = num_ff;
      face_in      = face_ff;
      sign_in      = sign_ff;
      mag_in       = mag_ff;
      mx_in        = mx_ff;
      sq_in        = sq_ff;
      len_in       = len_ff;
      newtan_in    = newtan_ff;
      rsp_index_in = rsp_index_ff;
      rsp_tan_in   = rsp_tan_ff;
      rsp_degen_in = rsp_degen_ff;
      rsp_done_in  = rsp_done_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in      = mta_pkg::kind_type'(req_kind);
               index_in     = req_vertex_index;
               corner_in[0] = req_vertex_index[AW-1:0];
               corner_in[1] = req_second_index[AW-1:0];
               corner_in[2] = req_third_index[AW-1:0];
               val_in[0]    = req_value_x;
               val_in[1]    = req_value_y;
               val_in[2]    = req_value_z;
               tu_in        = req_tex_u;
               tv_in        = req_tex_v;
               last_in      = req_last_triangle;
               step_in      = '0;
               comp_in      = '0;
               sel_in       = '0;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            // the tangent read for a read item is issued here
            unique case (kind_ff)
               mta_pkg::KIND_LOAD_GEO: state_in = S_RESP;
               mta_pkg::KIND_LOAD_TAN: state_in = S_RESP;
               mta_pkg::KIND_TRIANGLE: state_in = S_GEO_RD;
               mta_pkg::KIND_READ_TAN: state_in = S_RD_CAP;
            endcase
         end
         S_RD_CAP: begin
            for (int k = 0; k < 3; k++) newtan_in[k] = tan_rdata[k];
            state_in = S_RESP;
         end
         S_GEO_RD: begin
            // read corners in turn, form edges as their data returns
            unique case (step_ff[1:0])
               2'd0: ;
               2'd1: base_in = geo_rdata;
               2'd2: begin
                  e1_in[0] = mta_pkg::diff31(geo_rdata.px, base_ff.px);
                  e1_in[1] = mta_pkg::diff31(geo_rdata.py, base_ff.py);
                  e1_in[2] = mta_pkg::diff31(geo_rdata.pz, base_ff.pz);
                  du1_in   = mta_pkg::diff31(geo_rdata.tu, base_ff.tu);
                  dv1_in   = mta_pkg::diff31(geo_rdata.tv, base_ff.tv);
               end
               2'd3: begin
                  e2_in[0] = mta_pkg::diff31(geo_rdata.px, base_ff.px);
                  e2_in[1] = mta_pkg::diff31(geo_rdata.py, base_ff.py);
                  e2_in[2] = mta_pkg::diff31(geo_rdata.pz, base_ff.pz);
                  du2_in   = mta_pkg::diff31(geo_rdata.tu, base_ff.tu);
                  dv2_in   = mta_pkg::diff31(geo_rdata.tv, base_ff.tv);
               end
            endcase
            if (step_ff[1:0] == 2'd3) begin
               step_in  = '0;
               state_in = S_MUL;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         S_MUL: begin
            prod_in  = mul_p;
            state_in = S_MACC;
         end
         S_MACC: begin
            // even steps hold the first product, odd steps subtract
            if (!step_ff[0]) begin
               acc_in = prod_ff;
            end else begin
               unique case (step_ff[2:1])
                  2'd0: det_in    = acc_ff - prod_ff;
                  2'd1: num_in[0] = acc_ff - prod_ff;
                  2'd2: num_in[1] = acc_ff - prod_ff;
                  2'd3: num_in[2] = acc_ff - prod_ff;
               endcase
            end
            if (step_ff == 3'd7) begin
               comp_in  = '0;
               state_in = S_FACE;
            end else begin
               step_in  = step_ff + 3'd1;
               state_in = S_MUL;
            end
         end
         S_FACE: begin
            if ((det_ff == '0) || face_over) begin
               face_in[comp_ff] = (det_ff == '0) ? 32'd0 : face_val;
               if (comp_ff == 2'd2) begin
                  comp_in  = '0;
                  sel_in   = '0;
                  state_in = S_TAN_RD;
               end else begin
                  comp_in = comp_ff + 2'd1;
               end
            end else begin
               state_in = S_FACE_WAIT;
            end
         end
         S_FACE_WAIT: begin
            if (div_status.done) begin
               face_in[comp_ff] = face_val;
               if (comp_ff == 2'd2) begin
                  comp_in  = '0;
                  sel_in   = '0;
                  state_in = S_TAN_RD;
               end else begin
                  comp_in  = comp_ff + 2'd1;
                  state_in = S_FACE;
               end
            end
         end
         S_TAN_RD: state_in = S_TAN_CAP;
         S_TAN_CAP: begin
            for (int k = 0; k < 3; k++) begin
               sign_in[k] = tsum[k][32];
               mag_in[k]  = tsum[k][32] ? 33'(-tsum[k]) : 33'(tsum[k]);
            end
            mx_in    = mag_in[0] | mag_in[1] | mag_in[2];
            state_in = S_NORM;
         end
         S_NORM: begin
            // bring the largest magnitude to exactly 31 bits
            if (mx_ff == '0) begin
               for (int k = 0; k < 3; k++) newtan_in[k] = '0;
               state_in = S_TAN_WR;
            end else if (mx_ff[32]) begin
               for (int k = 0; k < 3; k++) mag_in[k] = mag_ff[k] >> 2;
               mx_in = mx_ff >> 2;
            end else if (mx_ff[31]) begin
               for (int k = 0; k < 3; k++) mag_in[k] = mag_ff[k] >> 1;
               mx_in = mx_ff >> 1;
            end else if (!mx_ff[30]) begin
               for (int k = 0; k < 3; k++) mag_in[k] = mag_ff[k] << 1;
               mx_in = mx_ff << 1;
            end else begin
               step_in  = '0;
               sq_in    = '0;
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            prod_in  = mul_p;
            state_in = S_SQ_ACC;
         end
         S_SQ_ACC: begin
            sq_in = sq_ff + 64'(prod_ff);
            if (step_ff == 3'd2) begin
               state_in = S_SQRT_WAIT;
            end else begin
               step_in  = step_ff + 3'd1;
               state_in = S_SQ;
            end
         end
         S_SQRT_WAIT: begin
            if (sqrt_status.done) begin
               len_in   = sqrt_root;
               comp_in  = '0;
               state_in = S_NDIV;
            end
         end
         S_NDIV: state_in = S_NDIV_WAIT;
         S_NDIV_WAIT: begin
            if (div_status.done) begin
               newtan_in[comp_ff] = sign_ff[comp_ff] ? (~ndiv_m + 32'd1) : ndiv_m;
               if (comp_ff == 2'd2) begin
                  comp_in  = '0;
                  state_in = S_TAN_WR;
               end else begin
                  comp_in  = comp_ff + 2'd1;
                  state_in = S_NDIV;
               end
            end
         end
         S_TAN_WR: begin
            // write back before the next corner reads, so repeats chain
            if (sel_ff == 2'd2) begin
               state_in = S_RESP;
            end else begin
               sel_in   = sel_ff + 2'd1;
               state_in = S_TAN_RD;
            end
         end
         S_RESP: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = index_ff;
               rsp_degen_in = 1'b0;
               rsp_done_in  = 1'b0;
               unique case (kind_ff)
                  mta_pkg::KIND_LOAD_GEO: rsp_tan_in = '{32'd0, 32'd0, 32'd0};
                  mta_pkg::KIND_LOAD_TAN: rsp_tan_in = val_ff;
                  mta_pkg::KIND_TRIANGLE: begin
                     rsp_tan_in   = face_ff;
                     rsp_degen_in = (det_ff == '0);
                     rsp_done_in  = last_ff;
                  end
                  mta_pkg::KIND_READ_TAN: rsp_tan_in = newtan_ff;
               endcase
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
         comp_ff      <= '0;
         sel_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         comp_ff      <= comp_in;
         sel_ff       <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      index_ff     <= index_in;
      corner_ff    <= corner_in;
      val_ff       <= val_in;
      tu_ff        <= tu_in;
      tv_ff        <= tv_in;
      last_ff      <= last_in;
      base_ff      <= base_in;
      e1_ff        <= e1_in;
      e2_ff        <= e2_in;
      du1_ff       <= du1_in;
      du2_ff       <= du2_in;
      dv1_ff       <= dv1_in;
      dv2_ff       <= dv2_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      det_ff       <= det_in;
      num_ff       <= num_in;
      face_ff      <= face_in;
      sign_ff      <= sign_in;
      mag_ff       <= mag_in;
      mx_ff        <= mx_in;
      sq_ff        <= sq_in;
      len_ff       <= len_in;
      newtan_ff    <= newtan_in;
      rsp_index_ff <= rsp_index_in;
      rsp_tan_ff   <= rsp_tan_in;
      rsp_degen_ff <= rsp_degen_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_index  = rsp_index_ff;
   assign rsp_tangent_x  = rsp_tan_ff[0];
   assign rsp_tangent_y  = rsp_tan_ff[1];
   assign rsp_tangent_z  = rsp_tan_ff[2];
   assign rsp_degenerate = rsp_degen_ff;
   assign rsp_mesh_done  = rsp_done_ff;

`ifndef NO_ASSERTIONS
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_status.busy)
      else $error("divider started while busy");

   a_sqrt_nonzero: assert property (@(posedge clock) disable iff (reset)
      sqrt_req.start |-> (sqrt_req.radicand != '0))
      else $error("square root of a zero sum");

   a_geo_after_accept: assert property (@(posedge clock) disable iff (reset)
      geo_we |-> $past(accept))
      else $error("geometry write without a preceding transfer");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |->
         (rsp_tangent_x == '0 && rsp_tangent_y == '0 && rsp_tangent_z == '0))
      else $error("degenerate triangle with nonzero face tangent");
`endif

endmodule

// ----- tb/mta_checker.sv -----
// ----------------------------------------------------------------------------
// mta_checker
// Watches the req and rsp channels of the mesh tangent accumulator, predicts
// each result from its own copy of the vertex store and compares field by
// field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module mta_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_kind,
   input  logic [11:0]        req_vertex_index,
   input  logic [11:0]        req_second_index,
   input  logic [11:0]        req_third_index,
   input  logic signed [31:0] req_value_x,
   input  logic signed [31:0] req_value_y,
   input  logic signed [31:0] req_value_z,
   input  logic signed [31:0] req_tex_u,
   input  logic signed [31:0] req_tex_v,
   input  logic               req_last_triangle,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [11:0]        rsp_out_index,
   input  logic signed [31:0] rsp_tangent_x,
   input  logic signed [31:0] rsp_tangent_y,
   input  logic signed [31:0] rsp_tangent_z,
   input  logic               rsp_degenerate,
   input  logic               rsp_mesh_done,
   output int                 errors,
   output int                 pending
);

   typedef struct {
      logic [11:0] index;
      logic [31:0] tx, ty, tz;
      logic        degen;
      logic        done;
   } tangent_result_type;

   logic [31:0] pos_x [mta_pkg::VERTEX_COUNT];
   logic [31:0] pos_y [mta_pkg::VERTEX_COUNT];
   logic [31:0] pos_z [mta_pkg::VERTEX_COUNT];
   logic [31:0] tex_u [mta_pkg::VERTEX_COUNT];
   logic [31:0] tex_v [mta_pkg::VERTEX_COUNT];
   logic [31:0] tan_x [mta_pkg::VERTEX_COUNT];
   logic [31:0] tan_y [mta_pkg::VERTEX_COUNT];
   logic [31:0] tan_z [mta_pkg::VERTEX_COUNT];

   tangent_result_type expected_tangents[$];

   initial begin
      errors  = 0;
      pending = 0;
   end

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
      errors++;
   endtask

   function automatic longint clip_delta(logic [31:0] a, logic [31:0] b);
      longint d;
      d = longint'($signed(a)) - longint'($signed(b));
      if (d > 64'sd1073741823) d = 64'sd1073741823;
      if (d < -64'sd1073741824) d = -64'sd1073741824;
      return d;
   endfunction

   // num * 2^30 / den, magnitude rounded half up, saturated to 32 bits
   function automatic logic [31:0] face_part(longint num, longint den);
      bit          neg;
      logic [63:0] n, d, q, r, m;
      neg = (num < 0) != (den < 0);
      n = num < 0 ? -num : num;
      d = den < 0 ? -den : den;
      q = n / d;
      r = n % d;
      if (q >= 2) begin
         m = 64'h1_0000_0000;
      end else begin
         m = q;
         repeat (31) begin
            r = r << 1;
            m = m << 1;
            if (r >= d) begin
               r = r - d;
               m = m | 64'd1;
            end
         end
         m = (m + 64'd1) >> 1;
      end
      if (neg) begin
         if (m > 64'h8000_0000) m = 64'h8000_0000;
         m = -m;
      end else if (m > 64'h7FFF_FFFF) begin
         m = 64'h7FFF_FFFF;
      end
      return m[31:0];
   endfunction

   function automatic logic [63:0] root_floor(logic [63:0] x);
      logic [63:0] res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x   = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // add the face tangent to one corner and renormalize in place
   function automatic void blend_corner(int idx, logic [31:0] fx, logic [31:0] fy,
                                        logic [31:0] fz);
      longint      s [3];
      logic [63:0] a [3];
      logic [63:0] mx, sq, len, m;
      int          bl;
      s[0] = longint'($signed(tan_x[idx])) + longint'($signed(fx));
      s[1] = longint'($signed(tan_y[idx])) + longint'($signed(fy));
      s[2] = longint'($signed(tan_z[idx])) + longint'($signed(fz));
      mx = 0;
      sq = 0;
      bl = 0;
      for (int i = 0; i < 3; i++) begin
         a[i] = s[i] < 0 ? -s[i] : s[i];
         if (a[i] > mx) mx = a[i];
      end
      if (mx == 0) begin
         tan_x[idx] = 0;
         tan_y[idx] = 0;
         tan_z[idx] = 0;
         return;
      end
      while (bl < 64 && (mx >> bl) != 0) bl++;
      for (int i = 0; i < 3; i++) begin
         if (bl > 31) a[i] = a[i] >> (bl - 31);
         else a[i] = a[i] << (31 - bl);
         sq = sq + a[i] * a[i];
      end
      len = root_floor(sq);
      for (int i = 0; i < 3; i++) begin
         m = ((a[i] << 30) + (len >> 1)) / len;
         a[i] = s[i] < 0 ? -m : m;
      end
      tan_x[idx] = a[0][31:0];
      tan_y[idx] = a[1][31:0];
      tan_z[idx] = a[2][31:0];
   endfunction

   function automatic tangent_result_type predict_tangent();
      tangent_result_type t;
      int     i0, i1, i2;
      longint du1, du2, dv1, dv2, det;
      longint e1 [3];
      longint e2 [3];
      logic [31:0] f [3];
      i0 = req_vertex_index;
      i1 = req_second_index;
      i2 = req_third_index;
      t = '{index: req_vertex_index, tx: 0, ty: 0, tz: 0, degen: 0, done: 0};
      case (mta_pkg::kind_type'(req_kind))
         mta_pkg::KIND_LOAD_GEO: begin
            pos_x[i0] = req_value_x;
            pos_y[i0] = req_value_y;
            pos_z[i0] = req_value_z;
            tex_u[i0] = req_tex_u;
            tex_v[i0] = req_tex_v;
         end
         mta_pkg::KIND_LOAD_TAN, mta_pkg::KIND_READ_TAN: begin
            if (mta_pkg::kind_type'(req_kind) == mta_pkg::KIND_LOAD_TAN) begin
               tan_x[i0] = req_value_x;
               tan_y[i0] = req_value_y;
               tan_z[i0] = req_value_z;
            end
            t.tx = tan_x[i0];
            t.ty = tan_y[i0];
            t.tz = tan_z[i0];
         end
         default: begin
            du1 = clip_delta(tex_u[i1], tex_u[i0]);
            du2 = clip_delta(tex_u[i2], tex_u[i0]);
            dv1 = clip_delta(tex_v[i1], tex_v[i0]);
            dv2 = clip_delta(tex_v[i2], tex_v[i0]);
            det = du1 * dv2 - du2 * dv1;
            e1[0] = clip_delta(pos_x[i1], pos_x[i0]);
            e1[1] = clip_delta(pos_y[i1], pos_y[i0]);
            e1[2] = clip_delta(pos_z[i1], pos_z[i0]);
            e2[0] = clip_delta(pos_x[i2], pos_x[i0]);
            e2[1] = clip_delta(pos_y[i2], pos_y[i0]);
            e2[2] = clip_delta(pos_z[i2], pos_z[i0]);
            for (int i = 0; i < 3; i++)
               f[i] = det == 0 ? 32'd0 : face_part(dv2 * e1[i] - dv1 * e2[i], det);
            blend_corner(i0, f[0], f[1], f[2]);
            blend_corner(i1, f[0], f[1], f[2]);
            blend_corner(i2, f[0], f[1], f[2]);
            t.tx    = f[0];
            t.ty    = f[1];
            t.tz    = f[2];
            t.degen = det == 0;
            t.done  = req_last_triangle;
         end
      endcase
      return t;
   endfunction

   always @(posedge clock) begin
      tangent_result_type want;
      if (reset) begin
         expected_tangents.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_tangents.size() == 0) begin
               report("unexpected transfer", rsp_out_index, 0);
            end else begin
               want = expected_tangents.pop_front();
               if (rsp_out_index !== want.index) report("out_index", rsp_out_index, want.index);
               if (rsp_tangent_x !== want.tx) report("tangent_x", rsp_tangent_x, want.tx);
               if (rsp_tangent_y !== want.ty) report("tangent_y", rsp_tangent_y, want.ty);
               if (rsp_tangent_z !== want.tz) report("tangent_z", rsp_tangent_z, want.tz);
               if (rsp_degenerate !== want.degen)
                  report("degenerate", rsp_degenerate, want.degen);
               if (rsp_mesh_done !== want.done) report("mesh_done", rsp_mesh_done, want.done);
            end
         end
         if (req_valid && req_ready) expected_tangents.push_back(predict_tangent());
      end
      pending = expected_tangents.size();
   end

endmodule

// ----- tb/tb_mesh_tangent_accumulator.sv -----
// ----------------------------------------------------------------------------
// tb_mesh_tangent_accumulator
// Drives loads, tangent reads and triangles into the accumulator with bursty
// traffic and a stalling receiver; the checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_mesh_tangent_accumulator;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_kind;
   logic [11:0]        req_vertex_index;
   logic [11:0]        req_second_index;
   logic [11:0]        req_third_index;
   logic signed [31:0] req_value_x;
   logic signed [31:0] req_value_y;
   logic signed [31:0] req_value_z;
   logic signed [31:0] req_tex_u;
   logic signed [31:0] req_tex_v;
   logic               req_last_triangle;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [11:0]        rsp_out_index;
   logic signed [31:0] rsp_tangent_x;
   logic signed [31:0] rsp_tangent_y;
   logic signed [31:0] rsp_tangent_z;
   logic               rsp_degenerate;
   logic               rsp_mesh_done;
   int                 errors;
   int                 pending;

   // which vertices hold defined geometry / tangent; never touch the others
   bit geo_ok [mta_pkg::VERTEX_COUNT];
   bit tan_ok [mta_pkg::VERTEX_COUNT];
   int burst_left;
   int stall_mode;
   int stall_left;

   mesh_tangent_accumulator dut (.*);

   mta_checker u_checker (.*);

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // receiver: switch stall style now and then at random, including always-ready stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_mode = 0;
         stall_left = 0;
      end else begin
         if ($urandom_range(0, 255) == 0) stall_mode = $urandom_range(0, 2);
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            default: begin
               // hold ready low for long stretches
               if (stall_left == 0) stall_left = $urandom_range(1, 30);
               stall_left--;
               rsp_ready <= stall_left < 3;
            end
         endcase
      end
   end

   // generous ceiling on the whole run
   initial begin
      #40_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // mostly a small pool so triangles find defined corners, sometimes anywhere
   function automatic logic [11:0] pick_vertex();
      case ($urandom_range(0, 9))
         0: return 12'($urandom_range(0, mta_pkg::VERTEX_COUNT - 1));
         1: return 12'hFFF;
         default: return 12'($urandom_range(0, 15));
      endcase
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 9))
         0, 1: return $urandom;
         2: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         default: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
      endcase
   endfunction

   // texture coordinates drawn from a tiny set now and then to force zero determinants
   function automatic logic [31:0] pick_tex();
      if ($urandom_range(0, 4) == 0) return $urandom_range(0, 1) ? 32'h0001_0000 : 32'h0;
      return pick_word();
   endfunction

   // present one item, hold it until transfer; burst gaps lower valid first
   task automatic issue(mta_pkg::kind_type kind, logic [11:0] a, logic [11:0] b,
                        logic [11:0] c, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                        logic [31:0] u, logic [31:0] v, logic last);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 40);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_valid         <= 1'b1;
      req_kind          <= kind;
      req_vertex_index  <= a;
      req_second_index  <= b;
      req_third_index   <= c;
      req_value_x       <= x;
      req_value_y       <= y;
      req_value_z       <= z;
      req_tex_u         <= u;
      req_tex_v         <= v;
      req_last_triangle <= last;
      do @(posedge clock); while (!req_ready);
      if (kind == mta_pkg::KIND_LOAD_GEO) geo_ok[a] = 1'b1;
      if (kind == mta_pkg::KIND_LOAD_TAN) tan_ok[a] = 1'b1;
   endtask

   task automatic geo(logic [11:0] a, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                      logic [31:0] u, logic [31:0] v);
      issue(mta_pkg::KIND_LOAD_GEO, a, 12'($urandom), 12'($urandom), x, y, z, u, v,
            1'($urandom));
   endtask

   task automatic tan(logic [11:0] a, logic [31:0] x, logic [31:0] y, logic [31:0] z);
      issue(mta_pkg::KIND_LOAD_TAN, a, 12'($urandom), 12'($urandom), x, y, z,
            $urandom, $urandom, 1'($urandom));
   endtask

   task automatic tri_item(logic [11:0] a, logic [11:0] b, logic [11:0] c, logic last);
      issue(mta_pkg::KIND_TRIANGLE, a, b, c, $urandom, $urandom, $urandom, $urandom,
            $urandom, last);
   endtask

   task automatic rd(logic [11:0] a);
      issue(mta_pkg::KIND_READ_TAN, a, 12'($urandom), 12'($urandom), $urandom, $urandom,
            $urandom, $urandom, $urandom, 1'($urandom));
   endtask

   // fill the first thing a corner still lacks, geometry before tangent; returns 1 if it was already complete
   task automatic make_ready(logic [11:0] a, output bit ready);
      ready = 1'b0;
      if (!geo_ok[a]) geo(a, pick_word(), pick_word(), pick_word(), pick_tex(), pick_tex());
      else if (!tan_ok[a]) tan(a, $urandom, $urandom, $urandom);
      else ready = 1'b1;
   endtask

   initial begin
      logic [11:0] a, b, c;
      bit          ra, rb, rc;
      int          roll;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_kind          = mta_pkg::KIND_LOAD_GEO;
      req_vertex_index  = '0;
      req_second_index  = '0;
      req_third_index   = '0;
      req_value_x       = '0;
      req_value_y       = '0;
      req_value_z       = '0;
      req_tex_u         = '0;
      req_tex_v         = '0;
      req_last_triangle = 1'b0;
      burst_left        = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: a unit right triangle, extremes, saturation, degenerate cases
      geo(0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
      geo(1, 32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0);
      geo(2, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000);
      geo(3, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0);
      geo(12'hFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
          32'h7FFF_FFFF);
      tan(0, 32'h0, 32'h0, 32'h0);
      tan(1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
      tan(2, 32'h4000_0000, 32'h0, 32'h0);
      tan(3, 32'h0, 32'h0, 32'h0);
      tan(12'hFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      rd(1);
      tri_item(0, 1, 2, 1'b0);
      // equal texcoords: zero determinant
      tri_item(0, 0, 3, 1'b0);
      // zero tangent plus zero face: zero-length sum
      tri_item(3, 3, 3, 1'b0);
      // saturated deltas and face tangent
      tri_item(0, 12'hFFF, 1, 1'b0);
      tri_item(12'hFFF, 2, 1, 1'b1);
      rd(3);
      rd(0);
      rd(12'hFFF);

      for (int n = 0; n < 950; n++) begin
         // pressure: let the block drain completely once
         if (n == 500) begin
            req_valid <= 1'b0;
            @(posedge clock);
            wait (pending == 0);
            @(posedge clock);
            burst_left = 0;
         end
         roll = $urandom_range(0, 99);
         a = pick_vertex();
         if (roll < 20) begin
            geo(a, pick_word(), pick_word(), pick_word(), pick_tex(), pick_tex());
         end else if (roll < 32) begin
            tan(a, $urandom, $urandom, $urandom);
         end else if (roll < 50) begin
            make_ready(a, ra);
            if (ra) rd(a);
         end else begin
            b = $urandom_range(0, 5) == 0 ? a : pick_vertex();
            c = pick_vertex();
            make_ready(a, ra);
            if (ra) make_ready(b, rb);
            if (ra && rb) make_ready(c, rc);
            if (ra && rb && rc) tri_item(a, b, c, $urandom_range(0, 7) == 0);
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (800) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
